FILE: design/evg_pkg.sv
// ----------------------------------------------------------------------------
// evg_pkg
// Shared types, constants and step functions of the vignette gain pipeline.
// ----------------------------------------------------------------------------
package evg_pkg;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [7:0]  alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } pix_out_t;

  // configuration register indexes
  localparam logic [2:0] CfgStrength  = 3'd0;
  localparam logic [2:0] CfgInner     = 3'd1;
  localparam logic [2:0] CfgFeather   = 3'd2;
  localparam logic [2:0] CfgRoundness = 3'd3;
  localparam logic [2:0] CfgOffsetX   = 3'd4;
  localparam logic [2:0] CfgOffsetY   = 3'd5;
  localparam logic [2:0] CfgWidth     = 3'd6;
  localparam logic [2:0] CfgHeight    = 3'd7;

  localparam int StepsPerStage = 4;
  localparam int DivW          = 64;
  localparam int DivStages     = DivW / StepsPerStage;
  localparam int RootW         = 32;
  localparam int SqrtStages    = RootW / StepsPerStage;
  localparam int ShadeLat      = 14;
  localparam int PipeLat       = 2 + DivStages + 1 + SqrtStages + ShadeLat;

  typedef struct packed {
    logic [63:0] nq;
    logic [25:0] rem;
  } div_st_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_st_t;

  function automatic logic [6:0] sat_pct(logic [6:0] p);
    return (p > 7'd100) ? 7'd100 : p;
  endfunction

  // restoring division, one quotient bit per step
  function automatic div_st_t div_steps(div_st_t st, logic [25:0] d);
    div_st_t     s;
    logic [26:0] t;
    s = st;
    for (int i = 0; i < StepsPerStage; i++) begin
      t    = {s.rem, s.nq[63]};
      s.nq = {s.nq[62:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t       = t - {1'b0, d};
        s.nq[0] = 1'b1;
      end
      s.rem = t[25:0];
    end
    return s;
  endfunction

  // digit by digit square root, one root bit per step
  function automatic sqrt_st_t sqrt_steps(sqrt_st_t st);
    sqrt_st_t    s;
    logic [35:0] t;
    logic [35:0] trial;
    s = st;
    for (int i = 0; i < StepsPerStage; i++) begin
      t     = {s.rem, s.rad[63:62]};
      trial = {2'b00, s.root, 2'b01};
      s.rad = {s.rad[61:0], 2'b00};
      if (t >= trial) begin
        t      = t - trial;
        s.root = {s.root[30:0], 1'b1};
      end else begin
        s.root = {s.root[30:0], 1'b0};
      end
      s.rem = t[33:0];
    end
    return s;
  endfunction

endpackage

FILE: design/elliptic_vignette_gain_core.sv
// ----------------------------------------------------------------------------
// elliptic_vignette_gain_core
// Per-pixel vignette gain on an RGBA stream with elliptic/circular distance.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_stall_o   evg_pkg::pix_in_t
//   out       output     out_valid_o / out_stall_i evg_pkg::pix_out_t
//   cfg       input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One pixel per clock while the output buffer has room; a result passes the offset
// stages, the 16-stage dividers, the 8-stage square roots and the shading stages.
// A two-entry output buffer takes results; the pipeline halts only when it is full.
// Reset clears valid bits, buffer state and loads the register defaults.
// ----------------------------------------------------------------------------
module elliptic_vignette_gain_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  evg_pkg::pix_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output evg_pkg::pix_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [12:0]       cfg_wdata_i
);

  localparam int          Lat       = evg_pkg::PipeLat;
  localparam logic [63:0] PctRecip  = 64'd10737419;

  function automatic logic [12:0] dim_sat(logic [12:0] d);
    if (d == '0) begin
      return 13'd1;
    end
    return (d > 13'd4096) ? 13'd4096 : d;
  endfunction

  function automatic logic [16:0] pct_q16(logic [6:0] p);
    logic [22:0] x;
    logic [63:0] m;
    x = {evg_pkg::sat_pct(p), 16'd0} + 23'd50;
    m = 64'(x) * PctRecip;
    return m[46:30];
  endfunction

  // configuration
  logic [8:0]  str_q;
  logic [6:0]  inner_pct_q, feath_pct_q, rnd_q;
  logic [12:0] offx_q, offy_q, width_q, height_q;
  logic [24:0] wsq_q, hsq_q;
  logic [25:0] dsq_q;
  logic [16:0] inner_q, feath_q;
  logic [16:0] feath_raw;
  logic [12:0] w_sat, h_sat;
  logic [25:0] wsq_d, hsq_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      str_q       <= '0;
      inner_pct_q <= 7'd50;
      feath_pct_q <= 7'd50;
      rnd_q       <= '0;
      offx_q      <= '0;
      offy_q      <= '0;
      width_q     <= 13'd1920;
      height_q    <= 13'd1080;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        evg_pkg::CfgStrength:  str_q       <= cfg_wdata_i[8:0];
        evg_pkg::CfgInner:     inner_pct_q <= cfg_wdata_i[6:0];
        evg_pkg::CfgFeather:   feath_pct_q <= cfg_wdata_i[6:0];
        evg_pkg::CfgRoundness: rnd_q       <= cfg_wdata_i[6:0];
        evg_pkg::CfgOffsetX:   offx_q      <= cfg_wdata_i;
        evg_pkg::CfgOffsetY:   offy_q      <= cfg_wdata_i;
        evg_pkg::CfgWidth:     width_q     <= cfg_wdata_i;
        evg_pkg::CfgHeight:    height_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_sat     = dim_sat(width_q);
    h_sat     = dim_sat(height_q);
    wsq_d     = 26'(w_sat) * 26'(w_sat);
    hsq_d     = 26'(h_sat) * 26'(h_sat);
    feath_raw = pct_q16(feath_pct_q);
  end

  // derived frame constants
  always_ff @(posedge clk_i) begin
    wsq_q   <= wsq_d[24:0];
    hsq_q   <= hsq_d[24:0];
    dsq_q   <= wsq_d + hsq_d;
    inner_q <= pct_q16(inner_pct_q);
    feath_q <= (feath_raw < 17'd66) ? 17'd66 : feath_raw;
  end

  // output buffer and pipeline enable
  evg_pkg::pix_out_t buf_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;
  logic              en, push, pop;

  assign en          = (cnt_q != 2'd2);
  assign in_stall_o  = !en;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = buf_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  // sidecar: valid, bypass and pixel travel beside the arithmetic
  logic [Lat-1:0]   side_v_q, side_b_q;
  evg_pkg::pix_in_t side_q [Lat];
  logic             bypass;

  assign bypass = (str_q == '0) || (in_data_i.alpha_in == '0);
  assign push   = en && side_v_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_v_q <= '0;
    end else if (en) begin
      side_v_q <= {side_v_q[Lat-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_b_q  <= {side_b_q[Lat-2:0], bypass};
      side_q[0] <= in_data_i;
      for (int k = 1; k < Lat; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // offsets from the doubled centre
  logic signed [15:0] cx, cy, px2, py2, dx2, dy2;
  logic [14:0]        ax_q, ay_q;
  logic [29:0]        sqx, sqy;
  logic [27:0]        sx_q, sy_q;
  logic [28:0]        sxy_q;

  always_comb begin
    cx  = $signed({3'b000, w_sat}) + $signed({{2{offx_q[12]}}, offx_q, 1'b0});
    cy  = $signed({3'b000, h_sat}) + $signed({{2{offy_q[12]}}, offy_q, 1'b0});
    px2 = $signed({3'b000, in_data_i.pixel_x, 1'b1});
    py2 = $signed({3'b000, in_data_i.pixel_y, 1'b1});
    dx2 = px2 - cx;
    dy2 = py2 - cy;
    sqx = 30'(ax_q) * 30'(ax_q);
    sqy = 30'(ay_q) * 30'(ay_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q  <= dx2[15] ? 15'(-dx2) : dx2[14:0];
      ay_q  <= dy2[15] ? 15'(-dy2) : dy2[14:0];
      sx_q  <= sqx[27:0];
      sy_q  <= sqy[27:0];
      sxy_q <= 29'(sqx[27:0]) + 29'(sqy[27:0]);
    end
  end

  // normalizing divisions
  logic [63:0] qx, qy, qc, rade_q, radc_q;
  logic [31:0] de, dc;

  evg_div u_div_x (
    .clk_i      (clk_i),
    .en_i       (en),
    .divisor_i  ({1'b0, wsq_q}),
    .dividend_i ({4'd0, sx_q, 32'd0}),
    .quotient_o (qx)
  );

  evg_div u_div_y (
    .clk_i      (clk_i),
    .en_i       (en),
    .divisor_i  ({1'b0, hsq_q}),
    .dividend_i ({4'd0, sy_q, 32'd0}),
    .quotient_o (qy)
  );

  evg_div u_div_c (
    .clk_i      (clk_i),
    .en_i       (en),
    .divisor_i  (dsq_q),
    .dividend_i ({3'd0, sxy_q, 32'd0}),
    .quotient_o (qc)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      rade_q <= qx + qy;
      radc_q <= qc;
    end
  end

  evg_sqrt u_sqrt_e (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rade_q),
    .root_o (de)
  );

  evg_sqrt u_sqrt_c (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (radc_q),
    .root_o (dc)
  );

  evg_pkg::pix_out_t shade_pix;
  evg_pkg::pix_out_t res;

  evg_shade u_shade (
    .clk_i       (clk_i),
    .en_i        (en),
    .de_i        (de),
    .dc_i        (dc),
    .strength_i  (str_q),
    .roundness_i (rnd_q),
    .inner_i     (inner_q),
    .feath_i     (feath_q),
    .pix_i       (side_q[Lat-2]),
    .pix_o       (shade_pix)
  );

  always_comb begin
    if (side_b_q[Lat-1]) begin
      res.red_out   = side_q[Lat-1].red_in;
      res.green_out = side_q[Lat-1].green_in;
      res.blue_out  = side_q[Lat-1].blue_in;
      res.alpha_out = side_q[Lat-1].alpha_in;
    end else begin
      res = shade_pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= res;
    end
  end

endmodule

FILE: design/evg_div.sv
// ----------------------------------------------------------------------------
// evg_div
// Pipelined restoring divider, 64-bit dividend, four quotient bits a stage.
// ----------------------------------------------------------------------------
module evg_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [25:0] divisor_i,
  input  logic [63:0] dividend_i,
  output logic [63:0] quotient_o
);

  evg_pkg::div_st_t st_q [evg_pkg::DivStages];
  evg_pkg::div_st_t st_d [evg_pkg::DivStages];
  evg_pkg::div_st_t init;

  always_comb begin
    init.nq  = dividend_i;
    init.rem = '0;
    st_d[0]  = evg_pkg::div_steps(init, divisor_i);
    for (int k = 1; k < evg_pkg::DivStages; k++) begin
      st_d[k] = evg_pkg::div_steps(st_q[k-1], divisor_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign quotient_o = st_q[evg_pkg::DivStages-1].nq;

endmodule

FILE: design/evg_sqrt.sv
// ----------------------------------------------------------------------------
// evg_sqrt
// Pipelined integer square root, 64-bit radicand, four root bits a stage.
// ----------------------------------------------------------------------------
module evg_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);

  evg_pkg::sqrt_st_t st_q [evg_pkg::SqrtStages];
  evg_pkg::sqrt_st_t st_d [evg_pkg::SqrtStages];
  evg_pkg::sqrt_st_t init;

  always_comb begin
    init.rad  = rad_i;
    init.rem  = '0;
    init.root = '0;
    st_d[0]   = evg_pkg::sqrt_steps(init);
    for (int k = 1; k < evg_pkg::SqrtStages; k++) begin
      st_d[k] = evg_pkg::sqrt_steps(st_q[k-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign root_o = st_q[evg_pkg::SqrtStages-1].root;

endmodule

FILE: design/evg_shade.sv
// ----------------------------------------------------------------------------
// evg_shade
// Distance blend, feathered smoothstep ramp, gain and channel scaling.
// ----------------------------------------------------------------------------
module evg_shade (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [31:0]       de_i,
  input  logic [31:0]       dc_i,
  input  logic [8:0]        strength_i,
  input  logic [6:0]        roundness_i,
  input  logic [16:0]       inner_i,
  input  logic [16:0]       feath_i,
  input  evg_pkg::pix_in_t  pix_i,
  output evg_pkg::pix_out_t pix_o
);

  localparam logic [25:0] DistCap     = 26'd33554432;
  localparam logic [63:0] BlendRecip  = 64'd2748779070;
  localparam logic [63:0] MagRecip    = 64'd42949673;
  localparam int          RampStages  = 4;

  typedef struct packed {
    logic        zero;
    logic        sat;
    logic [16:0] rem;
    logic [15:0] q;
  } ramp_t;

  function automatic ramp_t ramp_steps(ramp_t st, logic [16:0] f);
    ramp_t       s;
    logic [17:0] t;
    s = st;
    for (int i = 0; i < evg_pkg::StepsPerStage; i++) begin
      t   = {s.rem, 1'b0};
      s.q = {s.q[14:0], 1'b0};
      if (t >= {1'b0, f}) begin
        t      = t - {1'b0, f};
        s.q[0] = 1'b1;
      end
      s.rem = t[16:0];
    end
    return s;
  endfunction

  function automatic logic [7:0] scale_ch(logic [7:0] c, logic [22:0] k);
    logic [31:0] p;
    if (k[22] || (k == '0)) begin
      return 8'd0;
    end
    p = 32'(c) * 32'(k[21:0]) + 32'd32768;
    return (p[31:16] > 16'd255) ? 8'd255 : p[23:16];
  endfunction

  logic [31:0] pe_q, pc_q, bsum_q;
  logic [25:0] d_q;
  ramp_t       rp0_q;
  ramp_t       rp_q [RampStages];
  ramp_t       rp_d [RampStages];
  logic [16:0] t2_q, t_q;
  logic [17:0] s_q;
  logic [26:0] x_q;
  logic [20:0] mag_q;
  logic [22:0] k_q;
  evg_pkg::pix_out_t pix_q;

  logic [25:0] de_c, dc_c, diff;
  logic [6:0]  rnd, rinv;
  logic [63:0] bprod, mprod;
  ramp_t       rp0_d;
  logic [16:0] t;
  logic [33:0] tt;
  logic [17:0] w3;
  logic [35:0] ps;
  logic [8:0]  as;
  logic [22:0] kd;

  always_comb begin
    de_c = (de_i > 32'(DistCap)) ? DistCap : de_i[25:0];
    dc_c = (dc_i > 32'(DistCap)) ? DistCap : dc_i[25:0];
    rnd  = evg_pkg::sat_pct(roundness_i);
    rinv = 7'd100 - rnd;
    bprod = 64'(bsum_q) * BlendRecip;

    diff       = d_q - {9'd0, inner_i};
    rp0_d.zero = !(d_q > {9'd0, inner_i});
    rp0_d.sat  = (d_q > {9'd0, inner_i}) && (diff >= {9'd0, feath_i});
    rp0_d.rem  = diff[16:0];
    rp0_d.q    = '0;
    rp_d[0]    = ramp_steps(rp0_q, feath_i);
    for (int k = 1; k < RampStages; k++) begin
      rp_d[k] = ramp_steps(rp_q[k-1], feath_i);
    end

    if (rp_q[RampStages-1].zero) begin
      t = '0;
    end else if (rp_q[RampStages-1].sat) begin
      t = 17'd65536;
    end else begin
      t = {1'b0, rp_q[RampStages-1].q};
    end
    tt = 34'(t) * 34'(t) + 34'd32768;
    w3 = 18'd196608 - {t_q, 1'b0};
    ps = 36'(t2_q) * 36'(w3) + 36'd32768;

    as    = strength_i[8] ? 9'(-strength_i) : strength_i;
    mprod = 64'(x_q) * MagRecip;
    kd    = strength_i[8] ? (23'd65536 + 23'(mag_q)) : (23'd65536 - 23'(mag_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pe_q   <= 32'(de_c) * 32'(rinv);
      pc_q   <= 32'(dc_c) * 32'(rnd);
      bsum_q <= pe_q + pc_q;
      d_q    <= bprod[63:38];
      rp0_q  <= rp0_d;
      rp_q   <= rp_d;
      t2_q   <= tt[32:16];
      t_q    <= t;
      s_q    <= ps[33:16];
      x_q    <= 27'(as) * 27'(s_q) + 27'd50;
      mag_q  <= mprod[52:32];
      k_q    <= kd;
      pix_q.red_out   <= scale_ch(pix_i.red_in, k_q);
      pix_q.green_out <= scale_ch(pix_i.green_in, k_q);
      pix_q.blue_out  <= scale_ch(pix_i.blue_in, k_q);
      pix_q.alpha_out <= pix_i.alpha_in;
    end
  end

  assign pix_o = pix_q;

endmodule
